/* hw/rtl/integer_alu_with_divide_unit_macros.svh */
// ----------------------------------------------------------------------------
// Integer ALU assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_WITH_DIVIDE_UNIT_MACROS_SVH
`define INTEGER_ALU_WITH_DIVIDE_UNIT_MACROS_SVH

// same-cycle implication
`define IALU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ialu assertion failed (same cycle)");

// next-cycle implication
`define IALU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ialu assertion failed (next cycle)");

`endif

/* hw/rtl/ialu_pkg.sv */
// ----------------------------------------------------------------------------
// Integer ALU package
// Opcodes, field widths, FSM states and the control/status bundles that
// pass between the sequencer and the serial datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPND_W         = 32;
    localparam int OP_W           = 4;

    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV = 4'd3;
    localparam logic [OP_W-1:0] OP_REM = 4'd4;
    localparam logic [OP_W-1:0] OP_AND = 4'd5;
    localparam logic [OP_W-1:0] OP_OR  = 4'd6;
    localparam logic [OP_W-1:0] OP_XOR = 4'd7;
    localparam logic [OP_W-1:0] OP_NOT = 4'd8;
    localparam logic [OP_W-1:0] OP_SHL = 4'd9;
    localparam logic [OP_W-1:0] OP_SHR = 4'd10;
    localparam logic [OP_W-1:0] OP_SAR = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_FIX,
        ST_HOLD
    } ialu_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic run_step;
        logic fix;
    } ialu_ctrl_t;

    typedef struct packed {
        logic mod_last;
        logic run_last;
    } ialu_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/integer_alu_with_divide_unit.sv */
// Sequencing: each input beat runs through ST_RUN, then ST_FIX and ST_HOLD into
//   the output register; shl/shr/sar first pass ST_MOD for the serial shift-amount modulo.
// The block takes no new beat until the current item has left ST_HOLD, as
//   the one-bit-per-cycle datapath loop holds one item at a time.
// Reset: aresetn synchronous active low; clears the sequencer, result valid
//   and the sticky divide-by-zero flag.
// ----------------------------------------------------------------------------
// Integer ALU with serial divide unit
// Sequencer, output register and sticky error flag around a bit-serial
// datapath. The output register lets a new beat in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_alu_with_divide_unit_macros.svh"

module integer_alu_with_divide_unit #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ialu_pkg::OP_W-1:0]          s_req_type,
    input  wire logic signed [ialu_pkg::OPND_W-1:0] s_operand_a,
    input  wire logic signed [ialu_pkg::OPND_W-1:0] s_operand_b,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [ialu_pkg::OPND_W-1:0]      m_result_value,
    output logic                                    m_divide_by_zero,
    output logic                                    m_error_seen
);

    localparam int OW = ialu_pkg::OPND_W;

    ialu_pkg::ialu_state_t state_reg, state_next;
    ialu_pkg::ialu_ctrl_t  ctrl;
    ialu_pkg::ialu_stat_t  stat;

    logic [DATA_WIDTH-1:0] core_result;
    logic                  core_dz;

    logic                  accept;
    logic                  is_shift;
    logic                  out_free;
    logic                  out_load;

    // output register and sticky flag
    logic                  m_valid_reg,  m_valid_next;
    logic                  sticky_reg,   sticky_next;
    logic signed [OW-1:0]  m_result_reg;
    logic                  m_dz_reg;
    logic                  m_err_reg;

    assign accept   = s_valid && s_ready;
    // shift ops need the amount reduced mod DATA_WIDTH first
    assign is_shift = s_req_type inside {ialu_pkg::OP_SHL, ialu_pkg::OP_SHR,
                                         ialu_pkg::OP_SAR};
    // the output slot is free if empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ialu_pkg::ST_IDLE: begin
                if (accept) state_next = is_shift ? ialu_pkg::ST_MOD : ialu_pkg::ST_RUN;
            end
            ialu_pkg::ST_MOD: begin
                if (stat.mod_last) state_next = ialu_pkg::ST_RUN;
            end
            ialu_pkg::ST_RUN: begin
                if (stat.run_last) state_next = ialu_pkg::ST_FIX;
            end
            ialu_pkg::ST_FIX: begin
                state_next = ialu_pkg::ST_HOLD;
            end
            ialu_pkg::ST_HOLD: begin
                if (out_free) state_next = ialu_pkg::ST_IDLE;
            end
            default: begin
                state_next = ialu_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_ready       = 1'b0;
        ctrl.load     = 1'b0;
        ctrl.mod_step = 1'b0;
        ctrl.run_step = 1'b0;
        ctrl.fix      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ialu_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
            end
            ialu_pkg::ST_MOD: begin
                ctrl.mod_step = 1'b1;
            end
            ialu_pkg::ST_RUN: begin
                ctrl.run_step = 1'b1;
            end
            ialu_pkg::ST_FIX: begin
                ctrl.fix = 1'b1;
            end
            ialu_pkg::ST_HOLD: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ialu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- serial datapath ----------------
    ialu_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .req_type  (s_req_type),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .stat      (stat),
        .result    (core_result),
        .div_zero  (core_dz)
    );

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        sticky_next  = sticky_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            sticky_next  = sticky_reg | core_dz;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sticky_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            sticky_reg  <= sticky_next;
        end
    end

    // payload: result sign-extended or cut to the 32-bit field
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_reg <= OW'(signed'(core_result));
            m_dz_reg     <= core_dz;
            m_err_reg    <= sticky_reg | core_dz;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_value   = m_result_reg;
    assign m_divide_by_zero = m_dz_reg;
    assign m_error_seen     = m_err_reg;

    // ---------------- assertions ----------------
    // sticky flag never clears outside reset
    `IALU_ASSERT_NXT(a_sticky_holds, aclk, aresetn, sticky_reg, sticky_reg)
    // a divide-by-zero beat always reports the sticky flag
    `IALU_ASSERT_IMP(a_dz_sets_err, aclk, aresetn, m_valid && m_divide_by_zero, m_error_seen)
    // a divide-by-zero beat carries all ones
    `IALU_ASSERT_IMP(a_dz_all_ones, aclk, aresetn, m_valid && m_divide_by_zero, m_result_value == '1)
    // a finished item lands in the output register
    `IALU_ASSERT_NXT(a_hold_writes, aclk, aresetn, state_reg == ialu_pkg::ST_HOLD && out_free, m_valid_reg)

endmodule

`default_nettype wire

/* hw/rtl/ialu_core.sv */
// ----------------------------------------------------------------------------
// Integer ALU serial datapath
// Bit-serial add/sub/logic, shift-add multiply, restoring divide, and
// one-bit-per-cycle shifts, with a serial modulo for the shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_core #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire ialu_pkg::ialu_ctrl_t              ctrl,
    input  wire logic [ialu_pkg::OP_W-1:0]         req_type,
    input  wire logic signed [ialu_pkg::OPND_W-1:0] operand_a,
    input  wire logic signed [ialu_pkg::OPND_W-1:0] operand_b,
    output ialu_pkg::ialu_stat_t                   stat,
    output logic [DATA_WIDTH-1:0]                  result,
    output logic                                   div_zero
);

    localparam int W     = DATA_WIDTH;
    localparam int OW    = ialu_pkg::OPND_W;
    localparam int SH_W  = $clog2(W);
    localparam int MAXN  = (W > OW) ? W : OW;
    localparam int CNT_W = $clog2(MAXN);
    localparam logic [SH_W:0]    W_MOD     = (SH_W+1)'(W);
    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(OW - 1);
    localparam logic [CNT_W-1:0] RUN_LAST  = CNT_W'(W - 1);

    logic [ialu_pkg::OP_W-1:0] op_reg,     op_next;
    logic [W-1:0]              a_reg,      a_next;
    logic [W-1:0]              b_reg,      b_next;
    logic [W-1:0]              acc_reg,    acc_next;
    logic                      carry_reg,  carry_next;
    logic                      na_reg,     na_next;
    logic                      nb_reg,     nb_next;
    logic                      dz_reg,     dz_next;
    logic [OW-1:0]             shsrc_reg,  shsrc_next;
    logic [SH_W-1:0]           shamt_reg,  shamt_next;
    logic [CNT_W-1:0]          cnt_reg,    cnt_next;

    // load-time operand prep
    logic [W-1:0] a_in, b_in, a_mag, b_mag;
    logic         in_div;

    assign a_in   = W'(operand_a);
    assign b_in   = W'(operand_b);
    assign a_mag  = a_in[W-1] ? (~a_in + W'(1)) : a_in;
    assign b_mag  = b_in[W-1] ? (~b_in + W'(1)) : b_in;
    assign in_div = (req_type == ialu_pkg::OP_DIV) || (req_type == ialu_pkg::OP_REM);

    // serial add/sub bit
    logic bb, sum_bit, carry_out;
    assign bb        = b_reg[0] ^ (op_reg == ialu_pkg::OP_SUB);
    assign sum_bit   = a_reg[0] ^ bb ^ carry_reg;
    assign carry_out = (a_reg[0] & bb) | (a_reg[0] & carry_reg) | (bb & carry_reg);

    // restoring divide step
    logic [W:0] pr, diff;
    assign pr   = {acc_reg, a_reg[W-1]};
    assign diff = pr - {1'b0, b_reg};

    // shift amount: (amount * 2 + bit) mod W, one compare-subtract per bit
    logic [SH_W:0] mod_t, mod_r;
    assign mod_t = {shamt_reg, shsrc_reg[OW-1]};
    assign mod_r = (mod_t >= W_MOD) ? (mod_t - W_MOD) : mod_t;

    logic shift_en;
    assign shift_en = cnt_reg < CNT_W'(shamt_reg);

    always_comb begin
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        dz_next    = dz_reg;
        shsrc_next = shsrc_reg;
        shamt_next = shamt_reg;
        cnt_next   = cnt_reg;

        if (ctrl.load) begin
            op_next    = req_type;
            a_next     = in_div ? a_mag : a_in;
            b_next     = in_div ? b_mag : b_in;
            acc_next   = '0;
            carry_next = (req_type == ialu_pkg::OP_SUB);
            na_next    = a_in[W-1];
            nb_next    = b_in[W-1];
            dz_next    = in_div && (b_in == '0);
            shsrc_next = operand_b;
            shamt_next = '0;
            cnt_next   = '0;
        end else if (ctrl.mod_step) begin
            shamt_next = mod_r[SH_W-1:0];
            shsrc_next = {shsrc_reg[OW-2:0], 1'b0};
            cnt_next   = stat.mod_last ? '0 : cnt_reg + CNT_W'(1);
        end else if (ctrl.run_step) begin
            cnt_next = cnt_reg + CNT_W'(1);
            case (op_reg)
                ialu_pkg::OP_ADD, ialu_pkg::OP_SUB: begin
                    acc_next   = {sum_bit, acc_reg[W-1:1]};
                    carry_next = carry_out;
                    a_next     = a_reg >> 1;
                    b_next     = b_reg >> 1;
                end
                ialu_pkg::OP_AND: begin
                    acc_next = {a_reg[0] & b_reg[0], acc_reg[W-1:1]};
                    a_next   = a_reg >> 1;
                    b_next   = b_reg >> 1;
                end
                ialu_pkg::OP_OR: begin
                    acc_next = {a_reg[0] | b_reg[0], acc_reg[W-1:1]};
                    a_next   = a_reg >> 1;
                    b_next   = b_reg >> 1;
                end
                ialu_pkg::OP_XOR: begin
                    acc_next = {a_reg[0] ^ b_reg[0], acc_reg[W-1:1]};
                    a_next   = a_reg >> 1;
                    b_next   = b_reg >> 1;
                end
                ialu_pkg::OP_NOT: begin
                    acc_next = {~a_reg[0], acc_reg[W-1:1]};
                    a_next   = a_reg >> 1;
                end
                ialu_pkg::OP_MUL: begin
                    acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
                    a_next   = a_reg << 1;
                    b_next   = b_reg >> 1;
                end
                ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                    // partial remainder stays below the divisor, so its top bit is clear
                    if (!dz_reg) begin
                        acc_next = diff[W] ? pr[W-1:0] : diff[W-1:0];
                        a_next   = {a_reg[W-2:0], ~diff[W]};
                    end
                end
                ialu_pkg::OP_SHL: begin
                    if (shift_en) a_next = a_reg << 1;
                end
                ialu_pkg::OP_SHR: begin
                    if (shift_en) a_next = a_reg >> 1;
                end
                ialu_pkg::OP_SAR: begin
                    if (shift_en) a_next = {a_reg[W-1], a_reg[W-1:1]};
                end
                default: begin
                end
            endcase
        end else if (ctrl.fix) begin
            case (op_reg)
                ialu_pkg::OP_ADD, ialu_pkg::OP_SUB, ialu_pkg::OP_AND, ialu_pkg::OP_OR,
                ialu_pkg::OP_XOR, ialu_pkg::OP_NOT, ialu_pkg::OP_MUL: begin
                    acc_next = acc_reg;
                end
                ialu_pkg::OP_DIV: begin
                    if (dz_reg)                acc_next = '1;
                    else if (na_reg ^ nb_reg)  acc_next = ~a_reg + W'(1);
                    else                       acc_next = a_reg;
                end
                ialu_pkg::OP_REM: begin
                    if (dz_reg)       acc_next = '1;
                    else if (na_reg)  acc_next = ~acc_reg + W'(1);
                    else              acc_next = acc_reg;
                end
                ialu_pkg::OP_SHL, ialu_pkg::OP_SHR, ialu_pkg::OP_SAR: begin
                    acc_next = a_reg;
                end
                default: begin
                    acc_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        dz_reg    <= dz_next;
        shsrc_reg <= shsrc_next;
        shamt_reg <= shamt_next;
        cnt_reg   <= cnt_next;
    end

    assign stat.mod_last = (cnt_reg == MOD_LAST);
    assign stat.run_last = (cnt_reg == RUN_LAST);
    assign result        = acc_reg;
    assign div_zero      = dz_reg;

endmodule

`default_nettype wire

/* verif/tb_integer_alu_with_divide_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer ALU with divide unit testbench
// Sends opcode/operand beats through a valid/ready request channel and checks
// every result beat against an in-bench ALU predictor. The predictor covers
// wrapping arithmetic, signed divide and remainder, and the divide-by-zero
// flags. A directed set of corner cases comes first, then random traffic.
// Both channels idle at random, and the receiver holds off once for a long
// stretch so the input side backs up.
// ----------------------------------------------------------------------------
module tb_integer_alu_with_divide_unit;

    // Opcodes the block does not define: they must answer zero, leave the flag
    localparam logic [ialu_pkg::OP_W-1:0] OP_UNUSED_FIRST = 4'd12;
    localparam logic [ialu_pkg::OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

    localparam logic [ialu_pkg::OPND_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [ialu_pkg::OPND_W-1:0] INT_MAX = 32'h7fff_ffff;
    localparam logic [ialu_pkg::OPND_W-1:0] ALL_ONE = 32'hffff_ffff;

    localparam int RANDOM_BEATS   = 900;
    localparam int SQUEEZE_CYCLES = 500;   // long receiver hold-off
    localparam int SQUEEZE_AT     = 150;   // results seen before the hold-off
    localparam int DRAIN_CYCLES   = 70;    // longest latency is for shifts
    // Worst wait with no beat moving: hold-off + shift latency + long gap,
    // taken several times over.
    localparam int IDLE_LIMIT     = 2000;

    typedef struct packed {
        logic [ialu_pkg::OP_W-1:0]   op;
        logic [ialu_pkg::OPND_W-1:0] a;
        logic [ialu_pkg::OPND_W-1:0] b;
    } alu_request_t;

    typedef struct packed {
        logic [ialu_pkg::OPND_W-1:0] value;
        logic                        div_zero;
        logic                        err_sticky;
    } alu_answer_t;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                               s_valid     = 1'b0;
    logic                               s_ready;
    logic [ialu_pkg::OP_W-1:0]          s_req_type  = '0;
    logic signed [ialu_pkg::OPND_W-1:0] s_operand_a = '0;
    logic signed [ialu_pkg::OPND_W-1:0] s_operand_b = '0;

    logic                               m_valid;
    logic                               m_ready     = 1'b0;
    logic signed [ialu_pkg::OPND_W-1:0] m_result_value;
    logic                               m_divide_by_zero;
    logic                               m_error_seen;

    always #5 aclk = ~aclk;

    integer_alu_with_divide_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_value   (m_result_value),
        .m_divide_by_zero (m_divide_by_zero),
        .m_error_seen     (m_error_seen)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    alu_request_t pending_reqs[$];     // beats waiting to be sent
    alu_answer_t  answers_due[$];      // predicted results, oldest first
    logic         zero_error_latched;  // bench copy of the sticky flag
    int           err_count    = 0;
    int           beats_sent   = 0;
    int           results_seen = 0;

    // ------------------------------------------------------------------------
    // ALU predictor: one answer per request, updates the sticky flag copy
    // ------------------------------------------------------------------------
    function automatic alu_answer_t alu_predict(alu_request_t rq);
        alu_answer_t                 ans;
        logic [ialu_pkg::OPND_W-1:0] mag_a;
        logic [ialu_pkg::OPND_W-1:0] mag_b;
        logic [ialu_pkg::OPND_W-1:0] quo;
        logic [ialu_pkg::OPND_W-1:0] rmd;
        logic [4:0]                  sh;
        ans.value    = '0;
        ans.div_zero = 1'b0;
        sh           = rq.b[4:0];   // b mod 32 as unsigned
        case (rq.op)
            ialu_pkg::OP_ADD: ans.value = rq.a + rq.b;
            ialu_pkg::OP_SUB: ans.value = rq.a - rq.b;
            ialu_pkg::OP_MUL: ans.value = rq.a * rq.b;
            ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                if (rq.b == '0) begin
                    ans.value    = ALL_ONE;
                    ans.div_zero = 1'b1;
                end else begin
                    // unsigned magnitudes, then fix signs: truncates toward
                    // zero, INT_MIN / -1 folds back to INT_MIN with rem 0
                    mag_a = rq.a[ialu_pkg::OPND_W-1] ? 32'd0 - rq.a : rq.a;
                    mag_b = rq.b[ialu_pkg::OPND_W-1] ? 32'd0 - rq.b : rq.b;
                    quo   = mag_a / mag_b;
                    rmd   = mag_a % mag_b;
                    if (rq.a[ialu_pkg::OPND_W-1] ^ rq.b[ialu_pkg::OPND_W-1]) quo = 32'd0 - quo;
                    if (rq.a[ialu_pkg::OPND_W-1]) rmd = 32'd0 - rmd;
                    ans.value = (rq.op == ialu_pkg::OP_DIV) ? quo : rmd;
                end
            end
            ialu_pkg::OP_AND: ans.value = rq.a & rq.b;
            ialu_pkg::OP_OR:  ans.value = rq.a | rq.b;
            ialu_pkg::OP_XOR: ans.value = rq.a ^ rq.b;
            ialu_pkg::OP_NOT: ans.value = ~rq.a;
            ialu_pkg::OP_SHL: ans.value = rq.a << sh;
            ialu_pkg::OP_SHR: ans.value = rq.a >> sh;
            ialu_pkg::OP_SAR: ans.value = $signed(rq.a) >>> sh;
            default: ans.value = '0;
        endcase
        if (ans.div_zero) zero_error_latched = 1'b1;
        ans.err_sticky = zero_error_latched;
        return ans;
    endfunction

    // Idle length: mostly short, a few long; none at all in quiet stretches
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Operands lean on the corners: extremes, small magnitudes, then anything
    function automatic logic [ialu_pkg::OPND_W-1:0] pick_operand();
        logic [ialu_pkg::OPND_W-1:0] corners[7];
        corners = '{32'd0, 32'd1, ALL_ONE, INT_MIN, INT_MAX, INT_MIN + 32'd1, 32'd2};
        case ($urandom_range(0, 9))
            0, 1:    return corners[$urandom_range(0, 6)];
            2, 3:    return $urandom_range(0, 1) ? 32'($urandom_range(0, 40))
                                                 : 32'd0 - 32'($urandom_range(1, 40));
            default: return $urandom();
        endcase
    endfunction

    function automatic alu_request_t random_request();
        alu_request_t rq;
        if ($urandom_range(0, 99) < 94)
            rq.op = 4'($urandom_range(ialu_pkg::OP_ADD, ialu_pkg::OP_SAR));
        else
            rq.op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        rq.a = pick_operand();
        rq.b = pick_operand();
        // a zero divisor now and then
        if ((rq.op == ialu_pkg::OP_DIV || rq.op == ialu_pkg::OP_REM)
            && $urandom_range(0, 9) == 0)
            rq.b = '0;
        return rq;
    endfunction

    task automatic flag_mismatch(string what, logic [ialu_pkg::OPND_W-1:0] got,
                                 logic [ialu_pkg::OPND_W-1:0] want);
        $display("MISMATCH result %0d %s: got %h want %h",
                 results_seen, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: predicts each beat as it is accepted, then either idles
    // for a random gap or puts the next pending beat on the bus.
    // ------------------------------------------------------------------------
    int send_gap;

    always @(posedge aclk) begin : drive_requests
        alu_request_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                answers_due.push_back(alu_predict('{s_req_type, s_operand_a, s_operand_b}));
                beats_sent <= beats_sent + 1;
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt          = pending_reqs.pop_front();
                s_req_type  <= nxt.op;
                s_operand_a <= nxt.a;
                s_operand_b <= nxt.b;
                s_valid     <= 1'b1;
                // first 40 beats of every 200 go back to back
                send_gap    <= pick_gap((beats_sent % 200) < 40);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready: random stalls after beats, one long hold-off so the
    // output register and datapath fill and s_ready drops.
    // ------------------------------------------------------------------------
    int  stall_left;
    int  hold_left;
    bit  squeeze_done;

    always @(posedge aclk) begin : drive_ready
        int g;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            squeeze_done <= 1'b0;
        end else if (!squeeze_done && results_seen == SQUEEZE_AT) begin
            m_ready      <= 1'b0;
            hold_left    <= SQUEEZE_CYCLES;
            squeeze_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= (hold_left == 1);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if (m_valid && m_ready) begin
            g          = pick_gap((results_seen % 200) < 40);
            stall_left <= g;
            m_ready    <= (g == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        alu_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                flag_mismatch("unexpected beat, value", m_result_value, '0);
            end else begin
                want = answers_due.pop_front();
                if (m_result_value !== want.value)
                    flag_mismatch("result_value", m_result_value, want.value);
                if (m_divide_by_zero !== want.div_zero)
                    flag_mismatch("divide_by_zero", 32'(m_divide_by_zero), 32'(want.div_zero));
                if (m_error_seen !== want.err_sticky)
                    flag_mismatch("error_seen", 32'(m_error_seen), 32'(want.err_sticky));
            end
            results_seen <= results_seen + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no beat on either channel ends the run
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: no beat for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial begin
        zero_error_latched = 1'b0;

        // directed corners; divides by zero come after some clean divides
        // so the sticky flag is seen both clear and set
        pending_reqs.push_back('{ialu_pkg::OP_ADD, INT_MAX, 32'd1});        // wraps
        pending_reqs.push_back('{ialu_pkg::OP_SUB, INT_MIN, 32'd1});        // wraps
        pending_reqs.push_back('{ialu_pkg::OP_MUL, INT_MIN, ALL_ONE});
        pending_reqs.push_back('{ialu_pkg::OP_MUL, INT_MAX, INT_MAX});
        pending_reqs.push_back('{ialu_pkg::OP_DIV, 32'd7, 32'hffff_fffe});  // 7 / -2
        pending_reqs.push_back('{ialu_pkg::OP_DIV, 32'hffff_fff9, 32'd2});  // -7 / 2
        pending_reqs.push_back('{ialu_pkg::OP_REM, 32'hffff_fff9, 32'd2});  // -7 % 2
        pending_reqs.push_back('{ialu_pkg::OP_REM, 32'd7, 32'hffff_fffe});  // 7 % -2
        pending_reqs.push_back('{ialu_pkg::OP_DIV, INT_MIN, ALL_ONE});      // most negative / -1
        pending_reqs.push_back('{ialu_pkg::OP_REM, INT_MIN, ALL_ONE});
        pending_reqs.push_back('{ialu_pkg::OP_DIV, INT_MAX, 32'd0});        // divide by zero
        pending_reqs.push_back('{ialu_pkg::OP_REM, INT_MIN, 32'd0});        // remainder by zero
        pending_reqs.push_back('{ialu_pkg::OP_DIV, INT_MIN, INT_MIN});      // flag stays set
        pending_reqs.push_back('{ialu_pkg::OP_AND, 32'hf0f0_a5a5, ALL_ONE});
        pending_reqs.push_back('{ialu_pkg::OP_OR,  32'h0f0f_0000, INT_MIN});
        pending_reqs.push_back('{ialu_pkg::OP_XOR, ALL_ONE, 32'h5555_aaaa});
        pending_reqs.push_back('{ialu_pkg::OP_NOT, INT_MAX, ALL_ONE});      // b ignored
        pending_reqs.push_back('{ialu_pkg::OP_SHL, ALL_ONE, 32'd31});
        pending_reqs.push_back('{ialu_pkg::OP_SHL, 32'd1, 32'd32});         // amount wraps to 0
        pending_reqs.push_back('{ialu_pkg::OP_SHR, ALL_ONE, 32'd31});
        pending_reqs.push_back('{ialu_pkg::OP_SAR, INT_MIN, 32'd31});
        pending_reqs.push_back('{ialu_pkg::OP_SAR, INT_MIN, ALL_ONE});      // high bits of b dropped
        pending_reqs.push_back('{ialu_pkg::OP_SHR, INT_MIN, 32'h7fff_ffe1});
        pending_reqs.push_back('{OP_UNUSED_FIRST, ALL_ONE, ALL_ONE});
        pending_reqs.push_back('{OP_UNUSED_LAST, INT_MIN, 32'd0});

        for (int i = 0; i < RANDOM_BEATS; i++)
            pending_reqs.push_back(random_request());

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid)
            @(posedge aclk);
        while (answers_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* integer_alu_with_divide_unit.f */
+incdir+hw/rtl
hw/rtl/ialu_pkg.sv
hw/rtl/ialu_core.sv
hw/rtl/integer_alu_with_divide_unit.sv
verif/tb_integer_alu_with_divide_unit.sv
